@@ hw/rtl/boot_ms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package boot_ms_pkg;

  // Command codes carried on in_tuser
  typedef enum logic [1:0] {
    CMD_POWER_ON  = 2'd0,
    CMD_WAKE_INIT = 2'd1,
    CMD_POLL      = 2'd2,
    CMD_REPORT    = 2'd3
  } cmd_t;

  // Entries of the timestamp memory; wake and wake-factor stamps always coincide
  typedef enum logic [1:0] {
    ENT_WAKE   = 2'd0,
    ENT_SOC    = 2'd1,
    ENT_RESUME = 2'd2,
    ENT_LINK   = 2'd3
  } ent_t;

  localparam int NUM_ENT = 4;

  // Report geometry
  localparam int REPORT_BYTES = 35;
  localparam int IDX_W        = 6;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPORT_BYTES - 1);

  // Wake factor codes
  localparam logic [1:0] FACTOR_WAKE   = 2'd1;
  localparam logic [1:0] FACTOR_RESUME = 2'd2;

  // Status byte values that count as edges
  localparam logic [7:0] STATUS_ON  = 8'h01;
  localparam logic [7:0] STATUS_OFF = 8'h00;

  // Flag byte bits
  localparam logic [7:0] FLAG_ALWAYS = 8'h01;
  localparam logic [7:0] FLAG_WAKE   = 8'h3E;
  localparam logic [7:0] FLAG_SOC    = 8'h40;
  localparam logic [7:0] FLAG_RESUME = 8'h80;
  localparam logic [7:0] LINK_SEEN   = 8'h01;

  // Kind of report byte
  typedef enum logic [2:0] {
    SEG_FLAGS,
    SEG_NOW,
    SEG_WAKE_ABS,
    SEG_ELAPSED,
    SEG_FACTOR,
    SEG_POWER,
    SEG_LINK
  } seg_t;

  typedef struct packed {
    seg_t       seg;
    ent_t       ent;
    logic [1:0] lane;   // byte of the 32-bit word, 3 is the most significant
  } byte_map_t;

  // Decode a report position into its source and byte lane
  function automatic byte_map_t byte_map(input logic [IDX_W-1:0] idx);
    byte_map_t        m;
    logic [IDX_W-1:0] start;
    m.seg = SEG_FLAGS;
    m.ent = ENT_WAKE;
    start = idx;
    case (idx) inside
      [6'd1:6'd4]:   begin m.seg = SEG_NOW;      start = 6'd1;  end
      [6'd5:6'd8]:   begin m.seg = SEG_WAKE_ABS; start = 6'd5;  end
      [6'd9:6'd12]:  begin m.seg = SEG_ELAPSED;  start = 6'd9;  end
      6'd13:         begin m.seg = SEG_FACTOR;                  end
      [6'd14:6'd17]: begin m.seg = SEG_POWER;    start = 6'd14; end
      [6'd18:6'd21]: begin m.seg = SEG_ELAPSED;  start = 6'd18; end
      [6'd22:6'd25]: begin
        m.seg = SEG_ELAPSED;
        m.ent = ENT_SOC;
        start = 6'd22;
      end
      [6'd26:6'd29]: begin
        m.seg = SEG_ELAPSED;
        m.ent = ENT_RESUME;
        start = 6'd26;
      end
      6'd30:         begin m.seg = SEG_LINK;                    end
      [6'd31:6'd34]: begin
        m.seg = SEG_ELAPSED;
        m.ent = ENT_LINK;
        start = 6'd31;
      end
      default:       begin m.seg = SEG_FLAGS;                   end
    endcase
    m.lane = 2'(start + 6'd3 - idx);
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/boot_milestone_timestamp_log.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | tdata                                   | tuser     | tlast
// in_     | slave     | time, sleep, power, soc, resume, link     | command   | -
// out_    | master    | report byte, report index                 | -         | last byte
//
// Init and poll words write each new timestamp through the write port of the time
// memory, one entry at a time (up to three for a poll); input ready stays low meanwhile.
// A report emits 35 bytes, one per cycle while out_tready is high, through a memory
// read stage and then the output register; input ready returns once the last byte is
// registered. A low out_tready holds the pipeline.
// Reset (rst_n, synchronous) clears flags and control; unwritten entries are masked.
module boot_milestone_timestamp_log
  import boot_ms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] time_now, [32] sleep_port_high, [64:33] power_info,
  // [72:65] soc_wake_status, [80:73] resume_wake_status, [88:81] link_up_status
  input  wire logic [95:0] in_tdata,
  // [1:0] command
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] report_byte, [13:8] report_index
  output logic [15:0]      out_tdata,
  output logic             out_tlast
);

  // Input fields
  cmd_t        cmd;
  logic [31:0] time_now;
  logic        sleep_hi;
  logic [31:0] power_info;
  logic [7:0]  soc_st;
  logic [7:0]  res_st;
  logic [7:0]  lnk_st;

  assign cmd        = cmd_t'(in_tuser);
  assign time_now   = in_tdata[31:0];
  assign sleep_hi   = in_tdata[32];
  assign power_info = in_tdata[64:33];
  assign soc_st     = in_tdata[72:65];
  assign res_st     = in_tdata[80:73];
  assign lnk_st     = in_tdata[88:81];

  // Log state held in flops
  logic [NUM_ENT-1:0] flags_r, flags_nxt;
  logic [1:0]         factor_r, factor_nxt;
  logic [31:0]        power_r, power_nxt;
  logic [7:0]         last_soc_r, last_soc_nxt;
  logic [7:0]         last_res_r, last_res_nxt;
  logic [7:0]         last_lnk_r, last_lnk_nxt;

  // Pending stamp writes
  logic [NUM_ENT-1:0] wr_mask_r, wr_mask_nxt;
  logic [NUM_ENT-1:0] new_mask;
  logic [31:0]        wr_time_r;
  logic               wr_en;
  ent_t               wr_addr;

  // Report generator
  logic               gen_r;
  logic [IDX_W-1:0]   idx_r;
  logic               s1_valid_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [31:0]        t5_r;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_last_r;

  // Time memory
  logic [31:0]        mem [NUM_ENT];
  logic [31:0]        rd_data_r;
  logic               rd_en;
  ent_t               rd_addr;
  byte_map_t          rd_bm;

  logic               in_acc;
  logic               out_free;
  logic               s1_en;
  logic               issue;
  logic               move;
  byte_map_t          bm;
  logic [31:0]        word;
  logic [7:0]         byte_val;

  assign in_tready = !gen_r && (wr_mask_r == '0);
  assign in_acc    = in_tvalid && in_tready;

  // Work out the new log state for one input word
  always_comb begin
    flags_nxt    = flags_r;
    factor_nxt   = factor_r;
    power_nxt    = power_r;
    last_soc_nxt = last_soc_r;
    last_res_nxt = last_res_r;
    last_lnk_nxt = last_lnk_r;
    new_mask     = '0;
    case (cmd) inside
      CMD_POWER_ON, CMD_WAKE_INIT: begin
        last_soc_nxt      = STATUS_OFF;
        last_res_nxt      = STATUS_OFF;
        last_lnk_nxt      = STATUS_OFF;
        flags_nxt         = '0;
        flags_nxt[ENT_WAKE] = 1'b1;
        new_mask          = '0;
        new_mask[ENT_WAKE] = 1'b1;
        factor_nxt = (cmd == CMD_WAKE_INIT && sleep_hi) ? FACTOR_RESUME : FACTOR_WAKE;
        power_nxt  = power_info;
      end
      CMD_POLL: begin
        if (soc_st == STATUS_ON && last_soc_r == STATUS_OFF) begin
          flags_nxt[ENT_SOC] = 1'b1;
          new_mask[ENT_SOC]  = 1'b1;
        end
        if (soc_st == STATUS_OFF && last_soc_r == STATUS_ON) begin
          flags_nxt           = '0;
          flags_nxt[ENT_WAKE] = 1'b1;
          new_mask            = '0;
          new_mask[ENT_WAKE]  = 1'b1;
          factor_nxt          = FACTOR_WAKE;
          power_nxt           = power_info;
        end
        last_soc_nxt = soc_st;
        if (res_st == STATUS_ON && last_res_r == STATUS_OFF) begin
          flags_nxt[ENT_RESUME] = 1'b1;
          new_mask[ENT_RESUME]  = 1'b1;
        end
        if (res_st == STATUS_OFF && last_res_r == STATUS_ON) begin
          flags_nxt           = '0;
          flags_nxt[ENT_WAKE] = 1'b1;
          new_mask            = '0;
          new_mask[ENT_WAKE]  = 1'b1;
          factor_nxt          = FACTOR_RESUME;
          power_nxt           = power_info;
        end
        last_res_nxt = res_st;
        if (lnk_st == STATUS_ON && last_lnk_r == STATUS_OFF) begin
          flags_nxt[ENT_LINK] = 1'b1;
          new_mask[ENT_LINK]  = 1'b1;
        end
        last_lnk_nxt = lnk_st;
      end
      default: begin
      end
    endcase
  end

  // Drain pending stamps one entry a cycle, lowest first
  always_comb begin
    wr_addr = ENT_WAKE;
    for (int i = NUM_ENT - 1; i >= 0; i--) begin
      if (wr_mask_r[i]) begin
        wr_addr = ent_t'(2'(i));
      end
    end
    wr_en       = (wr_mask_r != '0);
    wr_mask_nxt = wr_mask_r;
    if (wr_en) begin
      wr_mask_nxt[wr_addr] = 1'b0;
    end
    if (in_acc) begin
      wr_mask_nxt = new_mask;
    end
  end

  // Log state and write queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      factor_r   <= '0;
      power_r    <= '0;
      last_soc_r <= '0;
      last_res_r <= '0;
      last_lnk_r <= '0;
      wr_mask_r  <= '0;
    end else begin
      wr_mask_r <= wr_mask_nxt;
      if (in_acc) begin
        flags_r    <= flags_nxt;
        factor_r   <= factor_nxt;
        power_r    <= power_nxt;
        last_soc_r <= last_soc_nxt;
        last_res_r <= last_res_nxt;
        last_lnk_r <= last_lnk_nxt;
      end
    end
  end

  // Hold the word's time for stamps and for the report
  always_ff @(posedge clk) begin
    if (in_acc) begin
      wr_time_r <= time_now;
      t5_r      <= time_now;
    end
  end

  // Read pipeline control
  assign out_free = !out_valid_r || out_tready;
  assign s1_en    = !s1_valid_r || out_free;
  assign issue    = gen_r && (idx_r <= LAST_IDX) && s1_en;
  assign move     = s1_valid_r && out_free;
  assign rd_en    = issue;
  assign rd_bm    = byte_map(idx_r);
  assign rd_addr  = rd_bm.ent;

  // Time memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_time_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Advance the generator index and read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r      <= 1'b0;
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc && cmd == CMD_REPORT) begin
        gen_r <= 1'b1;
        idx_r <= '0;
      end else begin
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (move && s1_idx_r == LAST_IDX) begin
          gen_r <= 1'b0;
        end
      end
      if (s1_en) begin
        s1_valid_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx_r <= idx_r;
    end
  end

  // Form the report byte from the read word
  always_comb begin
    bm       = byte_map(s1_idx_r);
    word     = '0;
    byte_val = '0;
    case (bm.seg)
      SEG_NOW:      word = t5_r;
      SEG_WAKE_ABS: word = flags_r[ENT_WAKE] ? rd_data_r : '0;
      SEG_ELAPSED:  word = flags_r[bm.ent] ? (t5_r - rd_data_r) : '0;
      SEG_POWER:    word = flags_r[ENT_WAKE] ? power_r : '0;
      default:      word = '0;
    endcase
    case (bm.seg)
      SEG_FLAGS: begin
        byte_val = FLAG_ALWAYS
                 | (flags_r[ENT_WAKE]   ? FLAG_WAKE   : 8'h00)
                 | (flags_r[ENT_SOC]    ? FLAG_SOC    : 8'h00)
                 | (flags_r[ENT_RESUME] ? FLAG_RESUME : 8'h00);
      end
      SEG_FACTOR: byte_val = flags_r[ENT_WAKE] ? {6'd0, factor_r} : 8'h00;
      SEG_LINK:   byte_val = flags_r[ENT_LINK] ? LINK_SEEN : 8'h00;
      default:    byte_val = word[bm.lane*8 +: 8];
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r <= byte_val;
      out_idx_r  <= s1_idx_r;
      out_last_r <= (s1_idx_r == LAST_IDX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_idx_r, out_byte_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // No stamp write lands while a report reads the memory
  a_no_write_during_report: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !gen_r)
    else $error("stamp write during report");

  // The read stage only holds bytes of a running report
  a_s1_within_report: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> gen_r)
    else $error("read stage valid outside report");

  // An accepted report request starts the generator
  a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd == CMD_REPORT) |=> (gen_r && idx_r == '0))
    else $error("report did not start");

  // The generator never issues past the final byte or while stamps are pending
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (idx_r <= LAST_IDX && wr_mask_r == '0))
    else $error("read issued out of range or with stamps pending");
`endif

endmodule

`default_nettype wire
